FILE: rtl/core/gaussian_source_injection_core_assert.svh
// ----------------------------------------------------------------------------
// gaussian_source_injection_core assertion macros
// Shared concurrent assertion forms for the source injection core.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_SOURCE_INJECTION_CORE_ASSERT_SVH
`define GAUSSIAN_SOURCE_INJECTION_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GSIC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gsic assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define GSIC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gsic assertion failed: next-cycle implication");

`endif

FILE: rtl/core/gsic_pkg.sv
// ----------------------------------------------------------------------------
// gsic_pkg
// Types, field widths and codes shared by the source injection core.
// ----------------------------------------------------------------------------
package gsic_pkg;

    localparam int DEF_MAX_COLS   = 256;
    localparam int DEF_MAX_ROWS   = 256;
    localparam int DEF_MAX_RADIUS = 8;

    // field widths
    localparam int AMP_W      = 24;
    localparam int WIDX_W     = 8;
    localparam int WVAL_W     = 16;
    localparam int POS_W      = 8;
    localparam int CELL_W     = 32;
    localparam int SRC_W      = 13;
    localparam int GRID_W     = 9;
    localparam int RAD_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // internal arithmetic widths, sized for the full parameter range
    localparam int CRD_W  = 14;                 // grid coordinates, signed
    localparam int OFS_W  = 6;                  // window offset -15..15
    localparam int D2_W   = 10;                 // squared distance up to 450
    localparam int WGT_W  = 17;                 // Q1.15 weight, 0..32768
    localparam int PROD_W = AMP_W + WGT_W + 1;  // signed product
    localparam int RND_W  = PROD_W - 15;        // product magnitude after rounding
    localparam int SUM_W  = CELL_W + 2;

    localparam logic [WGT_W-1:0] WEIGHT_ONE = 17'd32768;

    // stream widths
    localparam int S_TDATA_W = 96;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;

    typedef enum logic [1:0] {
        REQ_INJECT      = 2'd0,
        REQ_LOAD_WEIGHT = 2'd1,
        REQ_READ_CELL   = 2'd2,
        REQ_WRITE_CELL  = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_COL    = 3'd0,
        CFG_SOURCE_ROW    = 3'd1,
        CFG_GRID_WIDTH    = 3'd2,
        CFG_GRID_HEIGHT   = 3'd3,
        CFG_SPREAD_RADIUS = 3'd4,
        CFG_SPREAD_MODE   = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic signed [SRC_W-1:0]  source_col;
        logic signed [SRC_W-1:0]  source_row;
        logic        [GRID_W-1:0] grid_width;
        logic        [GRID_W-1:0] grid_height;
        logic        [RAD_W-1:0]  spread_radius;
        logic                     spread_mode;
    } t_cfg;

    typedef struct packed {
        t_req                      req_type;
        logic signed [AMP_W-1:0]   amplitude;
        logic        [WIDX_W-1:0]  weight_index;
        logic        [WVAL_W-1:0]  weight_value;
        logic        [POS_W-1:0]   cell_col;
        logic        [POS_W-1:0]   cell_row;
        logic signed [CELL_W-1:0]  cell_value;
    } t_item;

    typedef struct packed {
        logic                      valid;
        logic signed [CELL_W-1:0]  read_value;
        logic                      saturated;
    } t_result;

endpackage

FILE: rtl/core/gaussian_source_injection_core.sv
// ----------------------------------------------------------------------------
// gaussian_source_injection_core
// 2D wavefield store with point or Gaussian-window source injection.
// ----------------------------------------------------------------------------
// Usage: one request word on the s_axis side (kind in tuser), one result word
// on the m_axis side for every request. Requests: inject, load weight, read
// cell, write cell. Configuration registers are written through the cfg port;
// the user must do so only while no request is outstanding, as the block
// does not enforce it. An injection walks a square window of side 2r+1 with
// r the clamped radius (zero in point mode); the walk does one field-store
// read-modify-write per in-grid window position through the shared
// multiply/round/saturate unit; that loop sets the injection time. One
// request is in flight at a time; tready drops on acceptance and rises once
// the result is in the output register.
// Reset: registers return to their reset values, then a clear pass writes
// zero to every store cell in turn; requests wait meanwhile, cfg writes are
// taken as usual.
// Stall: a result waits in the output register while m_axis_tready is low;
// the next request may be accepted, its result holds until the slot frees.
// ----------------------------------------------------------------------------
`include "gaussian_source_injection_core_assert.svh"

module gaussian_source_injection_core #(
    parameter int MAX_COLS   = gsic_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = gsic_pkg::DEF_MAX_ROWS,
    parameter int MAX_RADIUS = gsic_pkg::DEF_MAX_RADIUS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [gsic_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [gsic_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // request stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: amplitude[23:0], weight_index[31:24], weight_value[47:32],
    //        cell_col[55:48], cell_row[63:56], cell_value[95:64]
    input  logic [gsic_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [gsic_pkg::S_TUSER_W-1:0]      i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: read_value[31:0], saturated[32], zero[39:33]
    output logic [gsic_pkg::M_TDATA_W-1:0]      o_m_axis_tdata
);
    import gsic_pkg::*;

    t_cfg    r_cfg;
    t_item   item;
    t_result res;
    logic    out_free;
    logic    r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_col    <= '0;
            r_cfg.source_row    <= '0;
            r_cfg.grid_width    <= GRID_W'(256);
            r_cfg.grid_height   <= GRID_W'(256);
            r_cfg.spread_radius <= '0;
            r_cfg.spread_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SOURCE_COL:    r_cfg.source_col    <= $signed(i_cfg_wdata[SRC_W-1:0]);
                CFG_SOURCE_ROW:    r_cfg.source_row    <= $signed(i_cfg_wdata[SRC_W-1:0]);
                CFG_GRID_WIDTH:    r_cfg.grid_width    <= i_cfg_wdata[GRID_W-1:0];
                CFG_GRID_HEIGHT:   r_cfg.grid_height   <= i_cfg_wdata[GRID_W-1:0];
                CFG_SPREAD_RADIUS: r_cfg.spread_radius <= i_cfg_wdata[RAD_W-1:0];
                CFG_SPREAD_MODE:   r_cfg.spread_mode   <= i_cfg_wdata[0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // unpack the request word
    always_comb begin
        item.req_type     = t_req'(i_s_axis_tuser);
        item.amplitude    = $signed(i_s_axis_tdata[23:0]);
        item.weight_index = i_s_axis_tdata[31:24];
        item.weight_value = i_s_axis_tdata[47:32];
        item.cell_col     = i_s_axis_tdata[55:48];
        item.cell_row     = i_s_axis_tdata[63:56];
        item.cell_value   = $signed(i_s_axis_tdata[95:64]);
    end

    // output slot frees when empty or when the current word is taken
    assign out_free = !r_m_valid || i_m_axis_tready;

    gsic_engine #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_item     (item),
        .i_out_free (out_free),
        .o_result   (res)
    );

    // output register: load a finished result, clear on handoff
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res.valid) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (res.valid) begin
            r_m_data <= {(M_TDATA_W - CELL_W - 1)'(0), res.saturated, res.read_value};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    `GSIC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `GSIC_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, res.valid, !r_m_valid || i_m_axis_tready)
    `GSIC_ASSERT_IMPL(a_sat_no_read, i_clk, i_rst_n, r_m_valid && r_m_data[CELL_W], r_m_data[CELL_W-1:0] == '0)

endmodule

FILE: rtl/core/gsic_ram.sv
// ----------------------------------------------------------------------------
// gsic_ram
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module gsic_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/gsic_mac.sv
// ----------------------------------------------------------------------------
// gsic_mac
// Shared weigh-and-accumulate unit: registered multiply, then round to
// nearest (ties away from zero) and a saturating add onto the old value.
// ----------------------------------------------------------------------------
module gsic_mac #(
    parameter int AW = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [gsic_pkg::AMP_W-1:0] i_amp,
    input  logic [gsic_pkg::WGT_W-1:0]        i_weight,
    input  logic signed [gsic_pkg::CELL_W-1:0] i_old,
    input  logic [AW-1:0]                     i_addr,
    output logic                              o_valid,
    output logic [AW-1:0]                     o_addr,
    output logic signed [gsic_pkg::CELL_W-1:0] o_sum,
    output logic                              o_sat
);
    import gsic_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 34'sd2147483647;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -34'sd2147483648;

    logic                      r_valid;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [CELL_W-1:0]  r_old;
    logic [AW-1:0]             r_addr;

    logic signed [PROD_W-1:0]  n_prod;
    logic                      neg;
    logic [PROD_W-1:0]         mag;
    logic [PROD_W-1:0]         mag_rnd;
    logic [RND_W-1:0]          rnd;
    logic signed [SUM_W-1:0]   addend;
    logic signed [SUM_W-1:0]   sum;

    assign n_prod = i_amp * $signed({1'b0, i_weight});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_prod <= n_prod;
        r_old  <= i_old;
        r_addr <= i_addr;
    end

    always_comb begin
        neg     = r_prod[PROD_W-1];
        mag     = neg ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        mag_rnd = mag + PROD_W'(16384);
        rnd     = mag_rnd[PROD_W-1:15];
        addend  = neg ? -$signed(SUM_W'(rnd)) : $signed(SUM_W'(rnd));
        sum     = SUM_W'(r_old) + addend;
        o_sat   = 1'b0;
        o_sum   = sum[CELL_W-1:0];
        if (sum > SUM_MAX) begin
            o_sum = SUM_MAX[CELL_W-1:0];
            o_sat = 1'b1;
        end else if (sum < SUM_MIN) begin
            o_sum = SUM_MIN[CELL_W-1:0];
            o_sat = 1'b1;
        end
    end

    assign o_valid = r_valid;
    assign o_addr  = r_addr;

endmodule

FILE: rtl/core/gsic_engine.sv
// ----------------------------------------------------------------------------
// gsic_engine
// Sequencer, field store and weight table: clears the store after reset,
// serves one request at a time and walks the injection window.
// ----------------------------------------------------------------------------
`include "gaussian_source_injection_core_assert.svh"

module gsic_engine #(
    parameter int MAX_COLS   = 256,
    parameter int MAX_ROWS   = 256,
    parameter int MAX_RADIUS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gsic_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gsic_pkg::t_item   i_item,
    input  logic              i_out_free,
    output gsic_pkg::t_result o_result
);
    import gsic_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WSLOTS = 2 * MAX_RADIUS * MAX_RADIUS + 1;
    localparam int WAW    = (WSLOTS > 1) ? $clog2(WSLOTS) : 1;

    function automatic logic [AW-1:0] addr_of(input logic [CRD_W-1:0] row,
                                              input logic [CRD_W-1:0] col);
        addr_of = AW'(row) * AW'(MAX_COLS) + AW'(col);
    endfunction

    t_state r_state, n_state;
    logic [AW-1:0]             r_clr;
    logic signed [OFS_W-1:0]   r_dx, r_dz;
    logic                      r_p1;
    logic [AW-1:0]             r_p1_addr;
    logic signed [AMP_W-1:0]   r_amp;
    logic                      r_sat;
    logic                      r_in_store;
    logic signed [CELL_W-1:0]  r_rd;

    logic                      fire;
    logic [CRD_W-1:0]          gw, gh, w_eff, h_eff;
    logic signed [CRD_W-1:0]   src_c, src_r, cx, cz, jx, jz;
    logic [OFS_W-1:0]          rad_u, ax, az;
    logic signed [OFS_W-1:0]   rad;
    logic                      last_pos, in_grid, in_store;
    logic [D2_W-1:0]           d2;
    logic [AW-1:0]             win_addr, item_addr;

    logic                      f_we;
    logic [AW-1:0]             f_waddr, f_raddr;
    logic [CELL_W-1:0]         f_wdata, f_rdata;
    logic                      w_we;
    logic [WGT_W-1:0]          w_wdata, w_rdata, w_clamped;

    logic                      mac_valid, mac_sat;
    logic [AW-1:0]             mac_addr;
    logic signed [CELL_W-1:0]  mac_sum;

    // effective grid, clamped source and window radius
    always_comb begin
        gw = CRD_W'(i_cfg.grid_width);
        gh = CRD_W'(i_cfg.grid_height);
        if (gw == '0)                    w_eff = CRD_W'(1);
        else if (gw > CRD_W'(MAX_COLS))  w_eff = CRD_W'(MAX_COLS);
        else                             w_eff = gw;
        if (gh == '0)                    h_eff = CRD_W'(1);
        else if (gh > CRD_W'(MAX_ROWS))  h_eff = CRD_W'(MAX_ROWS);
        else                             h_eff = gh;

        src_c = CRD_W'(i_cfg.source_col);
        src_r = CRD_W'(i_cfg.source_row);
        if (src_c < 0)                               cx = '0;
        else if (src_c > $signed(w_eff - CRD_W'(1))) cx = $signed(w_eff - CRD_W'(1));
        else                                         cx = src_c;
        if (src_r < 0)                               cz = '0;
        else if (src_r > $signed(h_eff - CRD_W'(1))) cz = $signed(h_eff - CRD_W'(1));
        else                                         cz = src_r;

        if (!i_cfg.spread_mode)                                    rad_u = '0;
        else if (OFS_W'(i_cfg.spread_radius) > OFS_W'(MAX_RADIUS)) rad_u = OFS_W'(MAX_RADIUS);
        else                                                       rad_u = OFS_W'(i_cfg.spread_radius);
        rad = $signed(rad_u);
    end

    // window position of this sweep step
    always_comb begin
        jx       = cx + CRD_W'(r_dx);
        jz       = cz + CRD_W'(r_dz);
        in_grid  = (jx >= 0) && (jx < $signed(w_eff)) && (jz >= 0) && (jz < $signed(h_eff));
        ax       = r_dx[OFS_W-1] ? OFS_W'(-r_dx) : OFS_W'(r_dx);
        az       = r_dz[OFS_W-1] ? OFS_W'(-r_dz) : OFS_W'(r_dz);
        d2       = D2_W'(ax) * D2_W'(ax) + D2_W'(az) * D2_W'(az);
        last_pos = (r_dx == rad) && (r_dz == rad);
        win_addr = addr_of(jz, jx);
        item_addr = addr_of(CRD_W'(i_item.cell_row), CRD_W'(i_item.cell_col));
        in_store = (CRD_W'(i_item.cell_col) < CRD_W'(MAX_COLS)) &&
                   (CRD_W'(i_item.cell_row) < CRD_W'(MAX_ROWS));
    end

    // next state
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        fire       = i_in_valid && o_in_ready;
        n_state    = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (fire) begin
                    case (i_item.req_type)
                        REQ_INJECT:    n_state = ST_SWEEP;
                        REQ_READ_CELL: n_state = ST_READ;
                        default:       n_state = ST_RESP;
                    endcase
                end
            end
            ST_SWEEP: begin
                if (last_pos) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!r_p1 && !mac_valid) n_state = ST_RESP;
            end
            ST_READ: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_p1    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            r_p1 <= (r_state == ST_SWEEP) && in_grid;
        end
    end

    // payload: sweep counters, latched item and result
    always_ff @(posedge i_clk) begin
        r_p1_addr <= win_addr;
        if (fire) begin
            r_dx       <= -rad;
            r_dz       <= -rad;
            r_amp      <= i_item.amplitude;
            r_sat      <= 1'b0;
            r_rd       <= '0;
            r_in_store <= in_store;
        end else begin
            if (r_state == ST_SWEEP) begin
                if (r_dz == rad) begin
                    r_dz <= -rad;
                    r_dx <= r_dx + OFS_W'(1);
                end else begin
                    r_dz <= r_dz + OFS_W'(1);
                end
            end
            if (mac_valid && mac_sat) r_sat <= 1'b1;
            if (r_state == ST_READ && r_in_store) r_rd <= $signed(f_rdata);
        end
    end

    // field store ports: clear pass, accumulate write-back, direct write
    always_comb begin
        f_we    = 1'b0;
        f_waddr = item_addr;
        f_wdata = i_item.cell_value;
        if (r_state == ST_CLEAR) begin
            f_we    = 1'b1;
            f_waddr = r_clr;
            f_wdata = '0;
        end else if (mac_valid) begin
            f_we    = 1'b1;
            f_waddr = mac_addr;
            f_wdata = mac_sum;
        end else if (fire && i_item.req_type == REQ_WRITE_CELL && in_store) begin
            f_we = 1'b1;
        end
        f_raddr = (r_state == ST_SWEEP) ? win_addr : item_addr;
    end

    // weight table load, saturated to one
    always_comb begin
        w_clamped = ({1'b0, i_item.weight_value} > WEIGHT_ONE) ? WEIGHT_ONE
                                                               : {1'b0, i_item.weight_value};
        w_wdata   = w_clamped;
        w_we      = fire && (i_item.req_type == REQ_LOAD_WEIGHT) &&
                    (CRD_W'(i_item.weight_index) < CRD_W'(WSLOTS));
    end

    gsic_ram #(
        .DEPTH (DEPTH),
        .WIDTH (CELL_W)
    ) u_field (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    gsic_ram #(
        .DEPTH (WSLOTS),
        .WIDTH (WGT_W)
    ) u_weight (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (WAW'(i_item.weight_index)),
        .i_wdata (w_wdata),
        .i_raddr (d2[WAW-1:0]),
        .o_rdata (w_rdata)
    );

    gsic_mac #(
        .AW (AW)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_p1),
        .i_amp    (r_amp),
        .i_weight (i_cfg.spread_mode ? w_rdata : WEIGHT_ONE),
        .i_old    ($signed(f_rdata)),
        .i_addr   (r_p1_addr),
        .o_valid  (mac_valid),
        .o_addr   (mac_addr),
        .o_sum    (mac_sum),
        .o_sat    (mac_sat)
    );

    assign o_result.valid      = (r_state == ST_RESP) && i_out_free;
    assign o_result.read_value = r_rd;
    assign o_result.saturated  = r_sat;

    `GSIC_ASSERT_IMPL(a_issue_from_sweep, i_clk, i_rst_n, r_p1, $past(r_state) == ST_SWEEP)
    `GSIC_ASSERT_IMPL(a_weight_load_idle, i_clk, i_rst_n, w_we, $past(r_state) != ST_SWEEP)
    `GSIC_ASSERT_IMPL(a_resp_drained, i_clk, i_rst_n, r_state == ST_RESP, !r_p1 && !mac_valid)

endmodule
